/* hdl/blp_pkg.sv */
// ----------------------------------------------------------------------------
// blp_pkg: shared types and constants of the Bresenham line pixel generator
// Output field widths, configuration register codes, sequencer states and
// the operation codes that drive the walker's shared adder.
// ----------------------------------------------------------------------------
package blp_pkg;

    localparam int PIX_W   = 6;   // pixel_x, pixel_y
    localparam int IDX_W   = 12;  // pixel_index
    localparam int CFG_W   = 7;   // screen_width, screen_height
    localparam int CFG_IDX_W = 1;

    typedef logic [CFG_IDX_W-1:0] cfg_index_t;
    typedef logic [CFG_W-1:0]     cfg_data_t;

    localparam cfg_index_t REG_SCREEN_WIDTH  = 1'b0;
    localparam cfg_index_t REG_SCREEN_HEIGHT = 1'b1;
    localparam cfg_data_t  SCREEN_RESET      = 7'd64;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SETUP,
        ST_INIT,
        ST_DIFF,
        ST_RUN
    } blp_state_t;

    // walker operations
    typedef enum logic [2:0] {
        WOP_HOLD,
        WOP_LOAD,   // capture endpoints
        WOP_SETUP,  // deltas, major axis, start point
        WOP_INIT,   // err = 2*minor - major
        WOP_DIFF,   // step increment = 2*minor - 2*major
        WOP_STEP    // advance one pixel
    } walk_op_t;

endpackage

/* hdl/blp_if.sv */
// ----------------------------------------------------------------------------
// blp_if: line and pixel channels
// Valid/ready channels carrying one line (two endpoints) and one pixel.
// ----------------------------------------------------------------------------
interface line_if #(
    parameter int COORD_BITS = 6
);
    logic                  valid;
    logic                  ready;
    logic [COORD_BITS-1:0] start_x;
    logic [COORD_BITS-1:0] start_y;
    logic [COORD_BITS-1:0] end_x;
    logic [COORD_BITS-1:0] end_y;

    modport source (output valid, start_x, start_y, end_x, end_y, input ready);
    modport sink   (input valid, start_x, start_y, end_x, end_y, output ready);
endinterface

interface pixel_if;
    import blp_pkg::*;
    logic             valid;
    logic             ready;
    logic [PIX_W-1:0] pixel_x;
    logic [PIX_W-1:0] pixel_y;
    logic [IDX_W-1:0] pixel_index;
    logic             on_screen;
    logic             last_pixel;

    modport source (output valid, pixel_x, pixel_y, pixel_index, on_screen, last_pixel,
                    input ready);
    modport sink   (input valid, pixel_x, pixel_y, pixel_index, on_screen, last_pixel,
                    output ready);
endinterface

/* hdl/bresenham_line_pixels.sv */
// ----------------------------------------------------------------------------
// bresenham_line_pixels: Bresenham line to pixel stream
// Takes one line per beat and emits its pixels in Bresenham order, each with
// its frame-buffer index, clip flag and a mark on the final pixel.
//
//   channel  | dir | beat
//   ---------+-----+---------------------------------------------
//   lines    | in  | start_x, start_y, end_x, end_y
//   pixels   | out | pixel_x, pixel_y, pixel_index, on_screen, last_pixel
//   cfg      | in  | cfg_write, cfg_index, cfg_data (width, height)
//
// A line is captured in IDLE and set up in SETUP, INIT and DIFF (the last two
// on the walker's shared adder); RUN then emits one pixel per cycle while
// pixels is not stalled. lines.ready is high only between lines.
// A stall on pixels holds the walker; the output register keeps its beat.
// Reset sets width and height to 64 and empties the output register.
// ----------------------------------------------------------------------------
module bresenham_line_pixels #(
    parameter int COORD_BITS = 6
) (
    input  logic                  clk,
    input  logic                  rst_n,
    line_if.sink                  lines,
    pixel_if.source               pixels,
    input  logic                  cfg_write,
    input  blp_pkg::cfg_index_t   cfg_index,
    input  blp_pkg::cfg_data_t    cfg_data
);
    import blp_pkg::*;

    blp_state_t state_reg, state_next;
    walk_op_t   op;

    cfg_data_t width_reg, height_reg;

    logic [COORD_BITS-1:0] wx, wy;
    logic                  wlast;
    logic [PIX_W-1:0]      mx, my;
    logic [IDX_W-1:0]      midx;
    logic                  mvis;

    logic             out_valid_reg;
    logic [PIX_W-1:0] px_reg, py_reg;
    logic [IDX_W-1:0] pidx_reg;
    logic             pvis_reg, plast_reg;
    logic             load;

    // configuration
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg  <= SCREEN_RESET;
            height_reg <= SCREEN_RESET;
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                REG_SCREEN_WIDTH:  width_reg  <= cfg_data;
                REG_SCREEN_HEIGHT: height_reg <= cfg_data;
                default:
                begin
                end
            endcase
        end
    end

    blp_walker #(
        .COORD_BITS (COORD_BITS)
    ) u_walker (
        .clk     (clk),
        .rst_n   (rst_n),
        .op      (op),
        .start_x (lines.start_x),
        .start_y (lines.start_y),
        .end_x   (lines.end_x),
        .end_y   (lines.end_y),
        .x       (wx),
        .y       (wy),
        .last    (wlast)
    );

    blp_pixel_map #(
        .COORD_BITS (COORD_BITS)
    ) u_map (
        .x           (wx),
        .y           (wy),
        .width       (width_reg),
        .height      (height_reg),
        .pixel_x     (mx),
        .pixel_y     (my),
        .pixel_index (midx),
        .on_screen   (mvis)
    );

    // sequencer
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= ST_IDLE;
        else
            state_reg <= state_next;
    end

    always_comb
    begin
        state_next  = state_reg;
        op          = WOP_HOLD;
        load        = 1'b0;
        lines.ready = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                lines.ready = 1'b1;
                if (lines.valid)
                begin
                    op         = WOP_LOAD;
                    state_next = ST_SETUP;
                end
            end
            ST_SETUP:
            begin
                op         = WOP_SETUP;
                state_next = ST_INIT;
            end
            ST_INIT:
            begin
                op         = WOP_INIT;
                state_next = ST_DIFF;
            end
            ST_DIFF:
            begin
                op         = WOP_DIFF;
                state_next = ST_RUN;
            end
            ST_RUN:
            begin
                // advance only when the output register frees up
                if (!out_valid_reg || pixels.ready)
                begin
                    load = 1'b1;
                    if (wlast)
                        state_next = ST_IDLE;
                    else
                        op = WOP_STEP;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (load)
            out_valid_reg <= 1'b1;
        else if (pixels.ready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            px_reg    <= mx;
            py_reg    <= my;
            pidx_reg  <= midx;
            pvis_reg  <= mvis;
            plast_reg <= wlast;
        end
    end

    assign pixels.valid       = out_valid_reg;
    assign pixels.pixel_x     = px_reg;
    assign pixels.pixel_y     = py_reg;
    assign pixels.pixel_index = pidx_reg;
    assign pixels.on_screen   = pvis_reg;
    assign pixels.last_pixel  = plast_reg;

    a_last_ends_line: assert property (@(posedge clk) disable iff (!rst_n)
        (load && wlast) |=> (state_reg == ST_IDLE))
        else $error("line did not end after its last pixel");

    a_off_screen_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !pvis_reg) |-> (pidx_reg == '0))
        else $error("off-screen pixel carries a non-zero index");

    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        load |-> (!out_valid_reg || pixels.ready))
        else $error("pending pixel overwritten");

    a_accept_starts_setup: assert property (@(posedge clk) disable iff (!rst_n)
        (lines.valid && lines.ready) |=> (state_reg == ST_SETUP))
        else $error("accepted line did not start setup");

endmodule

/* hdl/blp_walker.sv */
// ----------------------------------------------------------------------------
// blp_walker: Bresenham walker with one shared error adder
// Holds the endpoints, works out the major axis and start point, and then
// steps one pixel per STEP operation. The error term, its start value and
// the diagonal increment all go through the same adder.
// ----------------------------------------------------------------------------
module blp_walker #(
    parameter int COORD_BITS = 6
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  blp_pkg::walk_op_t     op,
    input  logic [COORD_BITS-1:0] start_x,
    input  logic [COORD_BITS-1:0] start_y,
    input  logic [COORD_BITS-1:0] end_x,
    input  logic [COORD_BITS-1:0] end_y,
    output logic [COORD_BITS-1:0] x,
    output logic [COORD_BITS-1:0] y,
    output logic                  last
);
    import blp_pkg::*;

    localparam int N = COORD_BITS;
    localparam int E = COORD_BITS + 3;

    logic [N-1:0] x1_reg, y1_reg, x2_reg, y2_reg;
    logic [N-1:0] major_reg, minor_reg, stop_reg;
    logic [N-1:0] amaj_reg, amin_reg;
    logic         xmajor_reg, step_up_reg;
    logic signed [E-1:0] err_reg, inc_step_reg;

    logic signed [N:0] dx, dy;
    logic [N-1:0]      adx, ady;
    logic              xmajor, step_up;
    logic signed [E-1:0] opa, opb, sum;
    logic signed [E-1:0] two_min, neg_maj;
    logic              hold;

    assign dx = $signed({1'b0, x2_reg}) - $signed({1'b0, x1_reg});
    assign dy = $signed({1'b0, y2_reg}) - $signed({1'b0, y1_reg});
    assign adx = dx[N] ? N'(-dx) : N'(dx);
    assign ady = dy[N] ? N'(-dy) : N'(dy);
    assign xmajor  = (ady <= adx);
    assign step_up = (dx[N] == dy[N]) && (dx != '0) && (dy != '0);

    assign two_min = E'({amin_reg, 1'b0});
    assign neg_maj = -(E'(amaj_reg));
    // x-major holds the minor axis while err < 0, y-major while err <= 0
    assign hold = err_reg[E-1] || (!xmajor_reg && err_reg == '0);

    // shared adder
    always_comb
    begin
        opa = err_reg;
        opb = hold ? two_min : inc_step_reg;
        unique case (op)
            WOP_INIT:
            begin
                opa = two_min;
                opb = neg_maj;
            end
            WOP_DIFF:
            begin
                opa = two_min;
                opb = E'(neg_maj <<< 1);
            end
            default:
            begin
                opa = err_reg;
                opb = hold ? two_min : inc_step_reg;
            end
        endcase
        sum = opa + opb;
    end

    always_ff @(posedge clk)
    begin
        unique case (op)
            WOP_LOAD:
            begin
                x1_reg <= start_x;
                y1_reg <= start_y;
                x2_reg <= end_x;
                y2_reg <= end_y;
            end
            WOP_SETUP:
            begin
                xmajor_reg  <= xmajor;
                step_up_reg <= step_up;
                if (xmajor)
                begin
                    amaj_reg  <= adx;
                    amin_reg  <= ady;
                    major_reg <= dx[N] ? x2_reg : x1_reg;
                    minor_reg <= dx[N] ? y2_reg : y1_reg;
                    stop_reg  <= dx[N] ? x1_reg : x2_reg;
                end
                else
                begin
                    amaj_reg  <= ady;
                    amin_reg  <= adx;
                    major_reg <= dy[N] ? y2_reg : y1_reg;
                    minor_reg <= dy[N] ? x2_reg : x1_reg;
                    stop_reg  <= dy[N] ? y1_reg : y2_reg;
                end
            end
            WOP_INIT:
            begin
                err_reg <= sum;
            end
            WOP_DIFF:
            begin
                inc_step_reg <= sum;
            end
            WOP_STEP:
            begin
                err_reg   <= sum;
                major_reg <= major_reg + N'(1);
                if (!hold)
                    minor_reg <= step_up_reg ? minor_reg + N'(1) : minor_reg - N'(1);
            end
            default:
            begin
            end
        endcase
    end

    assign x    = xmajor_reg ? major_reg : minor_reg;
    assign y    = xmajor_reg ? minor_reg : major_reg;
    assign last = (major_reg == stop_reg);

    // never step past the far endpoint
    a_no_step_past_end: assert property (@(posedge clk) disable iff (!rst_n)
        op == WOP_STEP |-> !last)
        else $error("walker stepped past the end of the line");

endmodule

/* hdl/blp_pixel_map.sv */
// ----------------------------------------------------------------------------
// blp_pixel_map: clip test and frame-buffer index of one pixel
// Index is (height - y - 1) * width + x, zero when the pixel is off screen.
// ----------------------------------------------------------------------------
module blp_pixel_map #(
    parameter int COORD_BITS = 6
) (
    input  logic [COORD_BITS-1:0]     x,
    input  logic [COORD_BITS-1:0]     y,
    input  blp_pkg::cfg_data_t        width,
    input  blp_pkg::cfg_data_t        height,
    output logic [blp_pkg::PIX_W-1:0] pixel_x,
    output logic [blp_pkg::PIX_W-1:0] pixel_y,
    output logic [blp_pkg::IDX_W-1:0] pixel_index,
    output logic                      on_screen
);
    import blp_pkg::*;

    localparam int CW = (COORD_BITS > CFG_W) ? COORD_BITS : CFG_W;

    logic [IDX_W-1:0] row;

    assign on_screen = (CW'(x) < CW'(width)) && (CW'(y) < CW'(height));
    assign row       = IDX_W'(height) - IDX_W'(y) - IDX_W'(1);
    assign pixel_index = on_screen ? IDX_W'(row * IDX_W'(width) + IDX_W'(x)) : '0;
    assign pixel_x   = PIX_W'(x);
    assign pixel_y   = PIX_W'(y);

endmodule

/* verif/bresenham_line_pixels_tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bresenham_line_pixels_tb: self-checking bench for the line pixel generator
// Drives lines from a directed table and then from random phases, each phase
// with its own screen size and idle pattern. An in-bench Bresenham walker
// predicts the pixel beats of untyped lines, typed rows supply their own; the
// pixel monitor checks each beat field by field against the oldest prediction.
// ----------------------------------------------------------------------------
module bresenham_line_pixels_tb;
    import blp_pkg::*;

    localparam int COORD_BITS      = 6;
    localparam int COORD_MAX       = (1 << COORD_BITS) - 1;
    localparam int STALL_LIMIT     = 3000;
    localparam int HOLD_OFF_CYCLES = 400;
    localparam int LINES_PER_PHASE = 50;
    localparam int N_PHASES        = 9;
    localparam int N_CASES         = 25;

    typedef struct packed {
        logic [PIX_W-1:0] x;
        logic [PIX_W-1:0] y;
        logic [IDX_W-1:0] index;
        logic             visible;
        logic             is_last;
    } pixel_t;

    // typed rows are single-pixel lines whose index and clip flag are given
    typedef struct {
        int width;
        int height;
        int sx;
        int sy;
        int ex;
        int ey;
        int typed;
        int index;
        int visible;
    } line_case_t;

    line_case_t line_cases [N_CASES] = '{
        '{64, 64, 0, 0, 0, 0, 1, 4032, 1},
        '{64, 64, 63, 63, 63, 63, 1, 63, 1},
        '{64, 64, 0, 63, 0, 63, 1, 0, 1},
        '{64, 64, 63, 0, 63, 0, 1, 4095, 1},
        '{64, 64, 0, 0, 63, 63, 0, 0, 0},
        '{64, 64, 63, 0, 0, 63, 0, 0, 0},
        '{64, 64, 0, 10, 63, 10, 0, 0, 0},
        '{64, 64, 20, 63, 20, 0, 0, 0, 0},
        '{64, 64, 5, 3, 40, 20, 0, 0, 0},
        '{64, 64, 40, 20, 5, 3, 0, 0, 0},
        '{64, 64, 3, 5, 20, 40, 0, 0, 0},
        '{64, 64, 20, 40, 3, 5, 0, 0, 0},
        '{64, 64, 0, 0, 2, 1, 0, 0, 0},
        '{64, 64, 0, 0, 1, 2, 0, 0, 0},
        '{64, 64, 63, 21, 42, 0, 0, 0, 0},
        '{64, 64, 10, 50, 12, 2, 0, 0, 0},
        '{32, 16, 0, 0, 63, 63, 0, 0, 0},
        '{32, 16, 40, 5, 40, 5, 1, 0, 0},
        '{0, 0, 0, 0, 0, 0, 1, 0, 0},
        '{0, 0, 63, 63, 0, 0, 0, 0, 0},
        '{127, 127, 63, 0, 63, 0, 1, 3777, 1},
        '{127, 127, 0, 0, 63, 40, 0, 0, 0},
        '{1, 1, 0, 0, 0, 0, 1, 0, 1},
        '{1, 1, 1, 0, 1, 0, 1, 0, 0},
        '{127, 1, 0, 0, 63, 5, 0, 0, 0}
    };

    // per phase: screen size and idle percentages; the last phase picks its size at random
    int phase_width  [N_PHASES] = '{64, 64, 64, 64, 1, 127, 40, 0, 64};
    int phase_height [N_PHASES] = '{64, 64, 64, 64, 1, 127, 23, 64, 64};
    int phase_send   [N_PHASES] = '{0, 72, 0, 22, 22, 0, 72, 0, 22};
    int phase_recv   [N_PHASES] = '{0, 0, 72, 22, 22, 0, 0, 72, 22};

    logic       clk;
    logic       rst_n;
    logic       cfg_write;
    cfg_index_t cfg_index;
    cfg_data_t  cfg_data;

    line_if #(.COORD_BITS(COORD_BITS)) line_bus ();
    pixel_if                           pixel_bus ();

    bresenham_line_pixels #(
        .COORD_BITS (COORD_BITS)
    ) dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .lines     (line_bus),
        .pixels    (pixel_bus),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    int     screen_w = 64;
    int     screen_h = 64;
    pixel_t pixels_due [$];
    int     fail_count = 0;
    int     send_idle_pct = 0;
    int     recv_stall_pct = 0;
    int     hold_off_req = 0;
    int     quiet_cycles = 0;

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    function automatic int clamp_coord(int v);
        return (v < 0) ? 0 : ((v > COORD_MAX) ? COORD_MAX : v);
    endfunction

    function automatic pixel_t shade_pixel(int x, int y, bit is_last);
        pixel_t p;
        int     ux;
        int     uy;
        int     flat;
        ux = x & COORD_MAX;
        uy = y & COORD_MAX;
        p.x = ux[PIX_W-1:0];
        p.y = uy[PIX_W-1:0];
        p.visible = (ux < screen_w) && (uy < screen_h);
        flat = p.visible ? (screen_h - uy - 1) * screen_w + ux : 0;
        p.index = flat[IDX_W-1:0];
        p.is_last = is_last;
        return p;
    endfunction

    // walk from the lower end of the major axis, stepping the minor axis on the error term
    function automatic void predict_line_pixels(int x1, int y1, int x2, int y2);
        int dx;
        int dy;
        int adx;
        int ady;
        int minor_step;
        int x;
        int y;
        int stop_at;
        int err;
        dx = x2 - x1;
        dy = y2 - y1;
        adx = (dx < 0) ? -dx : dx;
        ady = (dy < 0) ? -dy : dy;
        minor_step = ((dx < 0 && dy < 0) || (dx > 0 && dy > 0)) ? 1 : -1;
        if (ady <= adx)
        begin
            err = 2 * ady - adx;
            if (dx >= 0)
            begin
                x = x1; y = y1; stop_at = x2;
            end
            else
            begin
                x = x2; y = y2; stop_at = x1;
            end
            pixels_due.push_back(shade_pixel(x, y, x >= stop_at));
            while (x < stop_at)
            begin
                x++;
                if (err < 0)
                    err += 2 * ady;
                else
                begin
                    y += minor_step;
                    err += 2 * (ady - adx);
                end
                pixels_due.push_back(shade_pixel(x, y, x >= stop_at));
            end
        end
        else
        begin
            err = 2 * adx - ady;
            if (dy >= 0)
            begin
                x = x1; y = y1; stop_at = y2;
            end
            else
            begin
                x = x2; y = y2; stop_at = y1;
            end
            pixels_due.push_back(shade_pixel(x, y, y >= stop_at));
            while (y < stop_at)
            begin
                y++;
                if (err <= 0)
                    err += 2 * adx;
                else
                begin
                    x += minor_step;
                    err += 2 * (adx - ady);
                end
                pixels_due.push_back(shade_pixel(x, y, y >= stop_at));
            end
        end
    endfunction

    // offer one line beat; returns at the edge that accepts it, valid left high
    task automatic send_line(int sx, int sy, int ex, int ey);
        @(negedge clk);
        while ($urandom_range(99) < send_idle_pct)
        begin
            line_bus.valid <= 1'b0;
            @(negedge clk);
        end
        line_bus.valid   <= 1'b1;
        line_bus.start_x <= sx[COORD_BITS-1:0];
        line_bus.start_y <= sy[COORD_BITS-1:0];
        line_bus.end_x   <= ex[COORD_BITS-1:0];
        line_bus.end_y   <= ey[COORD_BITS-1:0];
        do
            @(posedge clk);
        while (!line_bus.ready);
    endtask

    // drop valid and hold until every predicted pixel has arrived
    task automatic drain_pixels();
        @(negedge clk);
        line_bus.valid <= 1'b0;
        while (pixels_due.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic set_screen(int w, int h);
        drain_pixels();
        @(negedge clk);
        cfg_write <= 1'b1;
        cfg_index <= REG_SCREEN_WIDTH;
        cfg_data  <= w[CFG_W-1:0];
        @(negedge clk);
        cfg_index <= REG_SCREEN_HEIGHT;
        cfg_data  <= h[CFG_W-1:0];
        @(negedge clk);
        cfg_write <= 1'b0;
        screen_w = w & 8'h7F;
        screen_h = h & 8'h7F;
    endtask

    task automatic pick_line(output int sx, output int sy, output int ex, output int ey);
        int shape;
        int d;
        shape = $urandom_range(99);
        sx = $urandom_range(COORD_MAX);
        sy = $urandom_range(COORD_MAX);
        ex = $urandom_range(COORD_MAX);
        ey = $urandom_range(COORD_MAX);
        if (shape < 30)
        begin
            // fully random endpoints
        end
        else if (shape < 55)
        begin
            ex = clamp_coord(sx + int'($urandom_range(8)) - 4);
            ey = clamp_coord(sy + int'($urandom_range(8)) - 4);
        end
        else if (shape < 65)
            ey = sy;
        else if (shape < 75)
            ex = sx;
        else if (shape < 85)
        begin
            d = $urandom_range(COORD_MAX);
            ex = clamp_coord($urandom_range(1) ? sx + d : sx - d);
            ey = clamp_coord($urandom_range(1) ? sy + d : sy - d);
        end
        else if (shape < 92)
        begin
            ex = sx;
            ey = sy;
        end
        else
        begin
            sx = $urandom_range(1) ? COORD_MAX : 0;
            sy = $urandom_range(1) ? COORD_MAX : 0;
            ex = $urandom_range(1) ? COORD_MAX : 0;
            ey = $urandom_range(1) ? COORD_MAX : 0;
        end
    endtask

    // pixel receiver: random stalls, plus a long hold-off on request
    initial
    begin
        int hold_left;
        pixel_bus.ready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_off_req > 0)
            begin
                hold_left = hold_off_req;
                hold_off_req = 0;
                pixel_bus.ready <= 1'b0;
                repeat (hold_left) @(negedge clk);
            end
            pixel_bus.ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    function automatic void check_field(string name, int want, int got);
        if (want != got)
        begin
            $error("%s: expected %0d, got %0d", name, want, got);
            fail_count++;
        end
    endfunction

    always @(posedge clk)
    begin
        pixel_t want;
        if (rst_n && pixel_bus.valid && pixel_bus.ready)
        begin
            if (pixels_due.size() == 0)
            begin
                $error("pixel beat with no line outstanding: x=%0d y=%0d",
                       pixel_bus.pixel_x, pixel_bus.pixel_y);
                fail_count++;
            end
            else
            begin
                want = pixels_due.pop_front();
                check_field("pixel_x", want.x, pixel_bus.pixel_x);
                check_field("pixel_y", want.y, pixel_bus.pixel_y);
                check_field("pixel_index", want.index, pixel_bus.pixel_index);
                check_field("on_screen", want.visible, pixel_bus.on_screen);
                check_field("last_pixel", want.is_last, pixel_bus.last_pixel);
            end
        end
    end

    // watchdog: end the run when nothing moves for too long
    always @(posedge clk)
    begin
        if ((line_bus.valid && line_bus.ready) || (pixel_bus.valid && pixel_bus.ready)
            || cfg_write)
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= STALL_LIMIT)
        begin
            $display("Test completed with failures");
            $finish;
        end
    end

    initial
    begin
        int     sx;
        int     sy;
        int     ex;
        int     ey;
        pixel_t typed_pix;
        rst_n            = 1'b0;
        cfg_write        = 1'b0;
        cfg_index        = REG_SCREEN_WIDTH;
        cfg_data         = '0;
        line_bus.valid   = 1'b0;
        line_bus.start_x = '0;
        line_bus.start_y = '0;
        line_bus.end_x   = '0;
        line_bus.end_y   = '0;
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        foreach (line_cases[i])
        begin
            if (line_cases[i].width != screen_w || line_cases[i].height != screen_h)
                set_screen(line_cases[i].width, line_cases[i].height);
            send_line(line_cases[i].sx, line_cases[i].sy, line_cases[i].ex, line_cases[i].ey);
            if (line_cases[i].typed != 0)
            begin
                typed_pix.x       = line_cases[i].sx[PIX_W-1:0];
                typed_pix.y       = line_cases[i].sy[PIX_W-1:0];
                typed_pix.index   = line_cases[i].index[IDX_W-1:0];
                typed_pix.visible = line_cases[i].visible[0];
                typed_pix.is_last = 1'b1;
                pixels_due.push_back(typed_pix);
            end
            else
                predict_line_pixels(line_cases[i].sx, line_cases[i].sy,
                                    line_cases[i].ex, line_cases[i].ey);
        end

        for (int phase = 0; phase < N_PHASES; phase++)
        begin
            if (phase == N_PHASES - 1)
                set_screen($urandom_range(127), $urandom_range(127));
            else
                set_screen(phase_width[phase], phase_height[phase]);
            send_idle_pct  = phase_send[phase];
            recv_stall_pct = phase_recv[phase];
            // hold the pixel side off while lines keep coming, so the input backs up
            if (phase == 0)
                hold_off_req = HOLD_OFF_CYCLES;
            for (int k = 0; k < LINES_PER_PHASE; k++)
            begin
                if (phase == 2 && k == LINES_PER_PHASE / 2)
                    drain_pixels();
                pick_line(sx, sy, ex, ey);
                send_line(sx, sy, ex, ey);
                predict_line_pixels(sx, sy, ex, ey);
            end
        end

        drain_pixels();
        repeat (20) @(posedge clk);
        if (fail_count == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule
